>>> hdl/telemetry_frame_decoder_top_defines.svh
// assertion macros for the telemetry frame decoder checker
// used by the checker file only, no other dependencies
`ifndef TELEMETRY_FRAME_DECODER_TOP_DEFINES_SVH
`define TELEMETRY_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define TFD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tfd check failed");

// next-cycle implication, held off during reset
`define TFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tfd check failed");

`endif

>>> hdl/tfd_pkg.sv
// shared types and constants of the telemetry frame decoder
// no dependencies
package tfd_pkg;

    localparam int DATA_W     = 8;
    localparam int COUNT_W    = 5;
    localparam int COORD_W    = 32;
    localparam int HEADING_W  = 16;
    localparam int SUM_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int M_TDATA_W  = 2 * COORD_W + HEADING_W;

    localparam logic [DATA_W-1:0]    HDR_BYTE     = 8'h55;
    localparam logic [DATA_W-1:0]    TRL_BYTE     = 8'hFF;
    localparam logic [COUNT_W-1:0]   HB_LAST_POS  = 5'd3;
    localparam logic [COUNT_W-1:0]   TM_LAST_POS  = 5'd14;
    localparam logic [COUNT_W-1:0]   SUM_POS      = 5'd12;
    localparam logic [HEADING_W-1:0] HEADING_MAX  = 16'd36000;

    localparam logic [COORD_W-1:0]   LAT_LIMIT_RST = 32'd900000000;
    localparam logic [COORD_W-1:0]   LON_LIMIT_RST = 32'd1800000000;

    localparam logic [CFG_IDX_W-1:0] REG_LATITUDE_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONGITUDE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        KIND_REJECT    = 2'd0,
        KIND_HEARTBEAT = 2'd1,
        KIND_TELEMETRY = 2'd2
    } frame_kind_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              end_of_datagram;
    } byte_item_t;

    typedef struct packed {
        frame_kind_t          frame_kind;
        logic [COORD_W-1:0]   latitude_raw;
        logic [COORD_W-1:0]   longitude_raw;
        logic [HEADING_W-1:0] heading_raw;
    } verdict_t;

endpackage

>>> hdl/tfd_in_stage.sv
// input register of the frame decoder, holds one byte transaction
// depends on tfd_pkg
module tfd_in_stage
    import tfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              take,
    output logic              item_valid,
    output byte_item_t        item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.data_byte       <= s_tdata;
            item_reg.end_of_datagram <= s_tlast;
        end
    end

endmodule

>>> hdl/tfd_frame_accum.sv
// per-datagram state, limit registers and the verdict logic
// depends on tfd_pkg
module tfd_frame_accum
    import tfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  byte_item_t           item,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    output verdict_t             verdict
);

    logic [COUNT_W-1:0]   count_reg,    count_next;
    logic [SUM_W-1:0]     sum_reg,      sum_next;
    logic [COORD_W-1:0]   lat_reg,      lat_next;
    logic [COORD_W-1:0]   lon_reg,      lon_next;
    logic [HEADING_W-1:0] hdg_reg,      hdg_next;
    logic [SUM_W-1:0]     rx_sum_reg,   rx_sum_next;
    logic                 hdr_ok_reg,   hdr_ok_next;
    logic                 stail_ok_reg, stail_ok_next;
    logic                 ltail_ok_reg, ltail_ok_next;
    logic [COORD_W-1:0]   lat_limit_reg;
    logic [COORD_W-1:0]   lon_limit_reg;
    logic [DATA_W-1:0]    b;
    logic [COUNT_W-1:0]   pos;
    logic                 is_hb;
    logic                 is_tm;

    assign b   = item.data_byte;
    assign pos = count_reg;

    always_comb begin
        count_next    = count_reg;
        sum_next      = sum_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        hdg_next      = hdg_reg;
        rx_sum_next   = rx_sum_reg;
        hdr_ok_next   = hdr_ok_reg;
        stail_ok_next = stail_ok_reg;
        ltail_ok_next = ltail_ok_reg;
        if (!pos[COUNT_W-1]) begin
            count_next = pos + 5'd1;
            if (pos < SUM_POS) begin
                sum_next = sum_reg + b;
            end
            if (pos < 5'd2 && b != HDR_BYTE) begin
                hdr_ok_next = 1'b0;
            end
            if ((pos == 5'd2 || pos == 5'd3) && b != TRL_BYTE) begin
                stail_ok_next = 1'b0;
            end
            if (pos >= 5'd2 && pos <= 5'd5) begin
                lat_next = {lat_reg[COORD_W-DATA_W-1:0], b};
            end else if (pos >= 5'd6 && pos <= 5'd9) begin
                lon_next = {lon_reg[COORD_W-DATA_W-1:0], b};
            end else if (pos == 5'd10 || pos == 5'd11) begin
                hdg_next = {hdg_reg[HEADING_W-DATA_W-1:0], b};
            end else if (pos == SUM_POS) begin
                rx_sum_next = b;
            end else if ((pos == 5'd13 || pos == 5'd14) && b != TRL_BYTE) begin
                ltail_ok_next = 1'b0;
            end
        end
    end

    assign is_hb = (pos == HB_LAST_POS) && hdr_ok_next && stail_ok_next;
    assign is_tm = (pos == TM_LAST_POS) && hdr_ok_next && ltail_ok_next
                   && (rx_sum_next == sum_next)
                   && (lat_next <= lat_limit_reg)
                   && (lon_next <= lon_limit_reg)
                   && (hdg_next <= HEADING_MAX);

    always_comb begin
        verdict.frame_kind    = KIND_REJECT;
        verdict.latitude_raw  = '0;
        verdict.longitude_raw = '0;
        verdict.heading_raw   = '0;
        if (is_hb) begin
            verdict.frame_kind = KIND_HEARTBEAT;
        end else if (is_tm) begin
            verdict.frame_kind    = KIND_TELEMETRY;
            verdict.latitude_raw  = lat_next;
            verdict.longitude_raw = lon_next;
            verdict.heading_raw   = hdg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.end_of_datagram)) begin
            count_reg    <= '0;
            sum_reg      <= '0;
            lat_reg      <= '0;
            lon_reg      <= '0;
            hdg_reg      <= '0;
            rx_sum_reg   <= '0;
            hdr_ok_reg   <= 1'b1;
            stail_ok_reg <= 1'b1;
            ltail_ok_reg <= 1'b1;
        end else if (step) begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            lat_reg      <= lat_next;
            lon_reg      <= lon_next;
            hdg_reg      <= hdg_next;
            rx_sum_reg   <= rx_sum_next;
            hdr_ok_reg   <= hdr_ok_next;
            stail_ok_reg <= stail_ok_next;
            ltail_ok_reg <= ltail_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_limit_reg <= LAT_LIMIT_RST;
            lon_limit_reg <= LON_LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LATITUDE_LIMIT:  lat_limit_reg <= cfg_data;
                REG_LONGITUDE_LIMIT: lon_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

>>> hdl/tfd_result_reg.sv
// output register for one verdict transaction
// depends on tfd_pkg
module tfd_result_reg
    import tfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  verdict_t             verdict,
    output logic                 out_free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser
);

    logic     valid_reg;
    logic     valid_next;
    verdict_t data_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.heading_raw, data_reg.longitude_raw, data_reg.latitude_raw};
    assign m_tuser  = data_reg.frame_kind;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= verdict;
        end
    end

endmodule

>>> hdl/telemetry_frame_decoder_top.sv
// path: the final byte sits in the input register, its verdict then shows on m_ from the
// result register; non-final bytes give no transaction
// throughput: one byte per cycle; a final byte waits while m_ holds a stalled result
// reset: aresetn synchronous active low; clears frame state and valids,
// limits return to 900000000 and 1800000000
module telemetry_frame_decoder_top
    import tfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] latitude_raw, [63:32] longitude_raw,
                                            // [79:64] heading_raw
    output logic [1:0]           m_tuser,   // [1:0] frame_kind
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    logic       item_valid;
    byte_item_t item;
    logic       out_free;
    logic       take;
    verdict_t   verdict;

    assign cfg_ready = 1'b1;
    assign take      = item_valid && (!item.end_of_datagram || out_free);

    tfd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    tfd_frame_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (take),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .verdict   (verdict)
    );

    tfd_result_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && item.end_of_datagram),
        .verdict  (verdict),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> hdl/tfd_checker.sv
// port-level checks of the telemetry frame decoder and their bind
// depends on tfd_pkg and telemetry_frame_decoder_top_defines.svh
`include "telemetry_frame_decoder_top_defines.svh"

module tfd_checker
    import tfd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // stalled transaction holds
    `TFD_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // payload is zero unless the frame is telemetry
    `TFD_ASSERT_NOW(a_zero_payload, aclk, aresetn, m_tvalid && m_tuser != KIND_TELEMETRY, m_tdata == '0)

    // accepted heading stays within range
    `TFD_ASSERT_NOW(a_heading_range, aclk, aresetn, m_tvalid && m_tuser == KIND_TELEMETRY, m_tdata[M_TDATA_W-1:2*COORD_W] <= HEADING_MAX)

endmodule

bind telemetry_frame_decoder_top tfd_checker u_tfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/telemetry_frame_decoder_checker.sv
`timescale 1ns / 1ps
// scoreboard for the telemetry frame decoder: watches the byte, result and register channels,
// predicts one verdict per datagram and compares every result transaction field by field
// depends on tfd_pkg only
module telemetry_frame_decoder_checker
    import tfd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    output int                   errors,
    output int                   outstanding
);

    localparam int COUNT_SAT = 16;
    localparam int POS_LAT   = 2;
    localparam int POS_LON   = 6;
    localparam int POS_HDG   = 10;
    localparam int POS_TAIL  = 13;

    logic [COORD_W-1:0]   lat_limit;
    logic [COORD_W-1:0]   lon_limit;

    logic [COUNT_W-1:0]   byte_cnt;
    logic [SUM_W-1:0]     run_sum;
    logic [SUM_W-1:0]     rx_sum;
    logic [COORD_W-1:0]   lat_acc;
    logic [COORD_W-1:0]   lon_acc;
    logic [HEADING_W-1:0] hdg_acc;
    logic                 hdr_ok;
    logic                 short_tail_ok;
    logic                 long_tail_ok;

    verdict_t pending_verdicts[$];
    int       mismatch_cnt = 0;
    int       queued = 0;

    assign errors      = mismatch_cnt;
    assign outstanding = queued;

    function automatic void clear_frame();
        byte_cnt      = '0;
        run_sum       = '0;
        rx_sum        = '0;
        lat_acc       = '0;
        lon_acc       = '0;
        hdg_acc       = '0;
        hdr_ok        = 1'b1;
        short_tail_ok = 1'b1;
        long_tail_ok  = 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // one byte of a datagram; on the final byte the verdict is queued
    function automatic void decode_byte(input logic [DATA_W-1:0] b, input logic last);
        logic [COUNT_W-1:0] pos;
        verdict_t           v;
        pos = byte_cnt;
        if (pos < COUNT_SAT) begin
            if (pos < SUM_POS)
                run_sum += b;
            if (pos < POS_LAT && b != HDR_BYTE)
                hdr_ok = 1'b0;
            if (pos >= POS_LAT && pos <= HB_LAST_POS && b != TRL_BYTE)
                short_tail_ok = 1'b0;
            if (pos >= POS_LAT && pos < POS_LON)
                lat_acc = {lat_acc[COORD_W-9:0], b};
            else if (pos >= POS_LON && pos < POS_HDG)
                lon_acc = {lon_acc[COORD_W-9:0], b};
            else if (pos >= POS_HDG && pos < SUM_POS)
                hdg_acc = {hdg_acc[HEADING_W-9:0], b};
            else if (pos == SUM_POS)
                rx_sum = b;
            else if (pos >= POS_TAIL && pos <= TM_LAST_POS && b != TRL_BYTE)
                long_tail_ok = 1'b0;
            byte_cnt = pos + 1'b1;
        end
        if (last) begin
            v = '0;
            v.frame_kind = KIND_REJECT;
            if (pos == HB_LAST_POS && hdr_ok && short_tail_ok) begin
                v.frame_kind = KIND_HEARTBEAT;
            end else if (pos == TM_LAST_POS && hdr_ok && long_tail_ok && rx_sum == run_sum
                         && lat_acc <= lat_limit && lon_acc <= lon_limit
                         && hdg_acc <= HEADING_MAX) begin
                v.frame_kind    = KIND_TELEMETRY;
                v.latitude_raw  = lat_acc;
                v.longitude_raw = lon_acc;
                v.heading_raw   = hdg_acc;
            end
            pending_verdicts.push_back(v);
            clear_frame();
        end
    endfunction

    always @(posedge aclk) begin
        verdict_t exp_v;
        if (!aresetn) begin
            lat_limit = LAT_LIMIT_RST;
            lon_limit = LON_LIMIT_RST;
            clear_frame();
            pending_verdicts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result transaction, expected none, actual kind %0d",
                             $time, m_tuser);
                end else begin
                    exp_v = pending_verdicts.pop_front();
                    check_field("frame_kind", 32'(exp_v.frame_kind), 32'(m_tuser));
                    check_field("latitude_raw", exp_v.latitude_raw, m_tdata[31:0]);
                    check_field("longitude_raw", exp_v.longitude_raw, m_tdata[63:32]);
                    check_field("heading_raw", 32'(exp_v.heading_raw), 32'(m_tdata[79:64]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LATITUDE_LIMIT:  lat_limit = cfg_data;
                    REG_LONGITUDE_LIMIT: lon_limit = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
        end
        queued = pending_verdicts.size();
    end

endmodule

>>> dv/telemetry_frame_decoder_top_test.sv
`timescale 1ns / 1ps
// testbench top for telemetry_frame_decoder_top: clock, reset, datagram stimulus with random
// idling and a long result stall, limit register phases and the final verdict
// depends on tfd_pkg, the decoder rtl and telemetry_frame_decoder_checker
module telemetry_frame_decoder_top_test;
    import tfd_pkg::*;

    localparam int LIMIT_CYCLES     = 400000;
    localparam int SINK_HOLD_CYCLES = 300;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    int tfd_errors;
    int tfd_outstanding;
    int cycle_cnt = 0;

    // stimulus side view of the limits, used only to aim values at the boundaries
    logic [COORD_W-1:0] lat_bound = LAT_LIMIT_RST;
    logic [COORD_W-1:0] lon_bound = LON_LIMIT_RST;
    logic [7:0]         frame_bytes[$];
    int                 bytes_sent = 0;
    int                 src_gap_pct = 0;
    bit                 quiet = 1'b0;
    bit                 hold_req = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    telemetry_frame_decoder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    telemetry_frame_decoder_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (tfd_errors),
        .outstanding (tfd_outstanding)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("[telemetry_frame_decoder_top] ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request, none in the quiet part
    initial begin
        int  gap_pct;
        bit  held;
        m_tready = 1'b0;
        gap_pct  = 0;
        held     = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 63) == 0)
                gap_pct = $urandom_range(0, 2) * 20;
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        bytes_sent += frame_bytes.size();
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        wait (tfd_outstanding == 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_limits(input logic [COORD_W-1:0] lat, input logic [COORD_W-1:0] lon);
        cfg_valid <= 1'b1;
        cfg_index <= REG_LATITUDE_LIMIT;
        cfg_data  <= lat;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_index <= REG_LONGITUDE_LIMIT;
        cfg_data  <= lon;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        lat_bound = lat;
        lon_bound = lon;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] bound);
        case ($urandom_range(0, 9))
            0:       return bound;
            1:       return bound + 1'b1;
            2:       return '0;
            3:       return '1;
            4:       return $urandom();
            default: return $urandom_range(0, bound);
        endcase
    endfunction

    function automatic logic [HEADING_W-1:0] pick_heading();
        case ($urandom_range(0, 9))
            0:       return HEADING_MAX;
            1:       return HEADING_MAX + 1'b1;
            2:       return '0;
            3:       return '1;
            4:       return 16'($urandom_range(0, 16'hFFFF));
            default: return 16'($urandom_range(0, HEADING_MAX));
        endcase
    endfunction

    function automatic void build_heartbeat();
        frame_bytes = {};
        frame_bytes.push_back(HDR_BYTE);
        frame_bytes.push_back(HDR_BYTE);
        frame_bytes.push_back(TRL_BYTE);
        frame_bytes.push_back(TRL_BYTE);
    endfunction

    function automatic void build_telemetry(input logic [COORD_W-1:0] lat,
                                            input logic [COORD_W-1:0] lon,
                                            input logic [HEADING_W-1:0] hdg);
        logic [SUM_W-1:0] sum;
        frame_bytes = {};
        frame_bytes.push_back(HDR_BYTE);
        frame_bytes.push_back(HDR_BYTE);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(lat[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(lon[8*i +: 8]);
        frame_bytes.push_back(hdg[15:8]);
        frame_bytes.push_back(hdg[7:0]);
        sum = '0;
        foreach (frame_bytes[i])
            sum += frame_bytes[i];
        frame_bytes.push_back(sum);
        frame_bytes.push_back(TRL_BYTE);
        frame_bytes.push_back(TRL_BYTE);
    endfunction

    // well-formed frames, some damaged, resized or overlong, and plain noise
    task automatic send_random_datagram();
        int pick;
        int damage;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            build_telemetry(pick_coord(lat_bound), pick_coord(lon_bound), pick_heading());
        end else if (pick < 75) begin
            build_heartbeat();
        end else begin
            frame_bytes = {};
            repeat ($urandom_range(1, 6))
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (pick < 75) begin
            damage = $urandom_range(0, 99);
            if (damage < 15) begin
                frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] ^=
                    8'(1 << $urandom_range(0, 7));
            end else if (damage < 25) begin
                if ($urandom_range(0, 1) == 0)
                    void'(frame_bytes.pop_back());
                else
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (damage < 35) begin
                repeat ($urandom_range(1, 9))
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 3) == 0)
            src_gap_pct = $urandom_range(0, 2) * 25;
        send_frame();
    endtask

    task automatic run_bytes(input int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n)
            send_random_datagram();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_LATITUDE_LIMIT;
        cfg_data  = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: heartbeat, lone byte, accepted frame at every limit, overlong frame
        build_heartbeat();
        send_frame();
        frame_bytes = {};
        frame_bytes.push_back(TRL_BYTE);
        send_frame();
        build_telemetry(LAT_LIMIT_RST, LON_LIMIT_RST, HEADING_MAX);
        send_frame();
        build_telemetry('0, '0, '0);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
        send_frame();
        settle();

        // reset limits, with a long result stall while bytes keep coming
        hold_req = 1'b1;
        run_bytes(200);
        settle();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       write_limits('1, '1);
                1:       write_limits('0, '0);
                2:       write_limits($urandom(), $urandom());
                3:       write_limits($urandom_range(0, 100000), $urandom());
                default: begin
                    quiet = 1'b1;
                    write_limits(LAT_LIMIT_RST, LON_LIMIT_RST);
                end
            endcase
            run_bytes(180);
            settle();
        end

        if (tfd_errors == 0)
            $display("[telemetry_frame_decoder_top] OK");
        else
            $display("[telemetry_frame_decoder_top] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tfd_pkg.sv
hdl/tfd_in_stage.sv
hdl/tfd_frame_accum.sv
hdl/tfd_result_reg.sv
hdl/telemetry_frame_decoder_top.sv
hdl/tfd_checker.sv
dv/telemetry_frame_decoder_checker.sv
dv/telemetry_frame_decoder_top_test.sv
